### src/lzwd_pkg.sv
// lzwd_pkg: shared types and constants for the lzss window decoder
// no dependencies; used by the decoder top level and its port checker
`default_nettype none

package lzwd_pkg;

    // the top LEN_TAIL entries of the window are not refilled at stream start
    localparam int unsigned LEN_TAIL  = 18;
    localparam logic [7:0]  FILL_BYTE = 8'h20;
    localparam logic [4:0]  MIN_MATCH = 5'd3;
    localparam logic [4:0]  MAX_MATCH = 5'd18;
    // output queue entries behind the window read
    localparam logic [1:0]  QUEUE_DEPTH = 2'd2;

    typedef enum logic [1:0] {
        PH_CTRL,
        PH_DATA,
        PH_HIGH
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,
        ST_COPY
    } ctl_state_t;

    // where a copied byte comes from once the window read returns
    typedef enum logic [1:0] {
        SRC_MEM,
        SRC_FWD,
        SRC_FILL,
        SRC_ZERO
    } src_t;

endpackage

`default_nettype wire

### src/lzwd_ram.sv
// lzwd_ram: generic single write port, single read port ram with registered read
// no dependencies; read during write to the same address returns the old data
`default_nettype none

module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/lzss_window_decoder.sv
// lzss_window_decoder: byte-serial lzss decoder over a history window held in one ram
// depends on lzwd_pkg and lzwd_ram
`default_nettype none

// Takes one compressed byte per input transaction and emits decoded bytes. An accepted
// literal is written to the window and the output queue in the cycle it is accepted.
// A match high byte starts a copy that first reduces the 12-bit position into the
// window (subtracting WINDOW_SIZE until it lies inside, which is needed only when the
// window is smaller than 4096), then reads the window ram once per copied byte: 3 to
// 18 bytes at one byte per cycle while the output is not stalled. The single ram port
// pair (one read, one write per cycle) sets that rate. The next input is taken once
// the copy's last read has returned. A two-entry output queue lets input continue
// while decoded bytes wait. There is no clearing pass at stream start or after reset:
// a write count since stream start tells which window entries hold bytes of the
// current stream, unwritten lower entries read as 0x20, and the top 18 entries carry
// valid bits that only reset clears.
module lzss_window_decoder #(
    parameter int WINDOW_SIZE = 4096
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic      [7:0] out_byte,
    output logic            out_last
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int FW = AW + 1;
    localparam int SW = (AW > 12) ? AW : 12;
    localparam int TW = $clog2(lzwd_pkg::LEN_TAIL);
    localparam logic [AW-1:0] START_A = AW'(WINDOW_SIZE - lzwd_pkg::LEN_TAIL);
    localparam logic [AW-1:0] LAST_A  = AW'(WINDOW_SIZE - 1);
    localparam logic [FW-1:0] FULL_F  = FW'(WINDOW_SIZE);
    localparam logic [SW:0]   WIN_EXT = (SW + 1)'(WINDOW_SIZE);

    lzwd_pkg::ctl_state_t state_reg, state_next;
    lzwd_pkg::phase_t     phase_reg, phase_next;
    logic [8:0]           flag_reg, flag_next;
    logic [7:0]           pend_reg, pend_next;
    logic [AW-1:0]        cursor_reg, cursor_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [lzwd_pkg::LEN_TAIL-1:0] tail_valid_reg, tail_valid_next;
    logic                 inflight_reg, inflight_next;
    logic [1:0]           occ_reg, occ_next;

    logic [SW-1:0]        seek_reg, seek_next;
    logic [AW-1:0]        rd_addr_reg, rd_addr_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic                 item_last_reg, item_last_next;
    logic                 fl_last_reg, fl_last_next;
    lzwd_pkg::src_t       src_reg, src_next;
    logic [7:0]           fwd_reg, fwd_next;
    logic [7:0]           q_data_reg [2];
    logic [7:0]           q_data_next [2];
    logic                 q_last_reg [2];
    logic                 q_last_next [2];

    logic          in_acc;
    logic          lit_acc;
    logic          pop;
    logic          issue;
    logic [1:0]    level;
    logic [1:0]    occ_pop;
    logic [7:0]    ram_rdata;
    logic [7:0]    arr_byte;
    logic          we;
    logic [7:0]    wdata;
    logic          wr_last;
    logic          rd_hi;
    logic [AW-1:0] rd_rel;
    logic [TW-1:0] rd_tail;
    logic [TW-1:0] wr_tail;
    logic          rd_written;
    logic          tail_hit;
    logic [7:0]    flag_shr;

    lzwd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .clk   (clk),
        .we    (we),
        .waddr (cursor_reg),
        .wdata (wdata),
        .re    (issue),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    assign in_stall  = !(state_reg == lzwd_pkg::ST_IDLE && !inflight_reg
                         && occ_reg < lzwd_pkg::QUEUE_DEPTH);
    assign in_acc    = in_valid && !in_stall;
    assign lit_acc   = in_acc && phase_reg == lzwd_pkg::PH_DATA && flag_reg[0];
    assign pop       = (occ_reg != 2'd0) && !out_stall;
    assign out_valid = (occ_reg != 2'd0);
    assign out_byte  = q_data_reg[0];
    assign out_last  = q_last_reg[0];

    // queue level after this cycle, counting the byte returning from the ram
    assign level   = occ_reg + {1'b0, inflight_reg} - {1'b0, pop};
    assign issue   = (state_reg == lzwd_pkg::ST_COPY) && (level < lzwd_pkg::QUEUE_DEPTH);
    assign occ_pop = occ_reg - {1'b0, pop};

    always_comb
    begin
        case (src_reg)
            lzwd_pkg::SRC_MEM:  arr_byte = ram_rdata;
            lzwd_pkg::SRC_FWD:  arr_byte = fwd_reg;
            lzwd_pkg::SRC_FILL: arr_byte = lzwd_pkg::FILL_BYTE;
            default:            arr_byte = 8'h00;
        endcase
    end

    // one write per cycle: the returning copy byte or an accepted literal
    assign we      = inflight_reg || lit_acc;
    assign wdata   = inflight_reg ? arr_byte : in_byte;
    assign wr_last = inflight_reg ? fl_last_reg : in_last;

    // distance of the read address from the stream start, in write order
    assign rd_hi      = (rd_addr_reg >= START_A);
    assign rd_rel     = rd_hi ? rd_addr_reg - START_A : rd_addr_reg + AW'(lzwd_pkg::LEN_TAIL);
    assign rd_tail    = TW'(rd_addr_reg - START_A);
    assign wr_tail    = TW'(cursor_reg - START_A);
    assign rd_written = ({1'b0, rd_rel} < fill_reg);
    assign tail_hit   = rd_hi && tail_valid_reg[rd_tail];
    assign flag_shr   = flag_reg[8:1];

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        flag_next       = flag_reg;
        pend_next       = pend_reg;
        cursor_next     = cursor_reg;
        fill_next       = fill_reg;
        tail_valid_next = tail_valid_reg;
        inflight_next   = 1'b0;
        seek_next       = seek_reg;
        rd_addr_next    = rd_addr_reg;
        cnt_next        = cnt_reg;
        item_last_next  = item_last_reg;
        fl_last_next    = fl_last_reg;
        src_next        = src_reg;
        fwd_next        = fwd_reg;

        // window write side
        if (we)
        begin
            if (cursor_reg >= START_A)
            begin
                tail_valid_next[wr_tail] = 1'b1;
            end
            if (wr_last)
            begin
                cursor_next = START_A;
                fill_next   = '0;
            end
            else
            begin
                cursor_next = (cursor_reg == LAST_A) ? '0 : cursor_reg + AW'(1);
                fill_next   = (fill_reg == FULL_F) ? fill_reg : fill_reg + FW'(1);
            end
        end

        unique case (state_reg)
            lzwd_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (phase_reg)
                        lzwd_pkg::PH_DATA:
                        begin
                            if (flag_reg[0])
                            begin
                                flag_next  = {1'b0, flag_shr};
                                phase_next = (flag_shr <= 8'd1) ? lzwd_pkg::PH_CTRL
                                                                : lzwd_pkg::PH_DATA;
                            end
                            else
                            begin
                                pend_next  = in_byte;
                                phase_next = lzwd_pkg::PH_HIGH;
                            end
                        end
                        lzwd_pkg::PH_HIGH:
                        begin
                            seek_next      = SW'({in_byte[7:4], pend_reg});
                            cnt_next       = {1'b0, in_byte[3:0]} + lzwd_pkg::MIN_MATCH;
                            item_last_next = in_last;
                            state_next     = lzwd_pkg::ST_SEEK;
                            flag_next      = {1'b0, flag_shr};
                            phase_next     = (flag_shr <= 8'd1) ? lzwd_pkg::PH_CTRL
                                                                : lzwd_pkg::PH_DATA;
                        end
                        default:
                        begin
                            flag_next  = {1'b1, in_byte};
                            phase_next = lzwd_pkg::PH_DATA;
                        end
                    endcase
                    if (in_last)
                    begin
                        flag_next  = '0;
                        phase_next = lzwd_pkg::PH_CTRL;
                        pend_next  = '0;
                        // a copy restarts the window at its final write instead
                        if (!lit_acc && phase_reg != lzwd_pkg::PH_HIGH)
                        begin
                            cursor_next = START_A;
                            fill_next   = '0;
                        end
                    end
                end
            end
            lzwd_pkg::ST_SEEK:
            begin
                if ({1'b0, seek_reg} >= WIN_EXT)
                begin
                    seek_next = SW'({1'b0, seek_reg} - WIN_EXT);
                end
                else
                begin
                    rd_addr_next = seek_reg[AW-1:0];
                    state_next   = lzwd_pkg::ST_COPY;
                end
            end
            lzwd_pkg::ST_COPY:
            begin
                if (issue)
                begin
                    inflight_next = 1'b1;
                    fl_last_next  = item_last_reg && (cnt_reg == 5'd1);
                    fwd_next      = arr_byte;
                    if (inflight_reg && rd_addr_reg == cursor_reg)
                    begin
                        src_next = lzwd_pkg::SRC_FWD;
                    end
                    else if (rd_written || tail_hit)
                    begin
                        src_next = lzwd_pkg::SRC_MEM;
                    end
                    else if (!rd_hi)
                    begin
                        src_next = lzwd_pkg::SRC_FILL;
                    end
                    else
                    begin
                        src_next = lzwd_pkg::SRC_ZERO;
                    end
                    rd_addr_next = (rd_addr_reg == LAST_A) ? '0 : rd_addr_reg + AW'(1);
                    cnt_next     = cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1)
                    begin
                        state_next = lzwd_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lzwd_pkg::ST_IDLE;
            end
        endcase
    end

    // output queue, head at entry 0
    always_comb
    begin
        q_data_next[0] = q_data_reg[0];
        q_data_next[1] = q_data_reg[1];
        q_last_next[0] = q_last_reg[0];
        q_last_next[1] = q_last_reg[1];
        if (pop)
        begin
            q_data_next[0] = q_data_reg[1];
            q_last_next[0] = q_last_reg[1];
        end
        if (we)
        begin
            if (occ_pop == 2'd0)
            begin
                q_data_next[0] = wdata;
                q_last_next[0] = wr_last;
            end
            else
            begin
                q_data_next[1] = wdata;
                q_last_next[1] = wr_last;
            end
        end
        occ_next = occ_pop + {1'b0, we};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lzwd_pkg::ST_IDLE;
            phase_reg      <= lzwd_pkg::PH_CTRL;
            flag_reg       <= '0;
            pend_reg       <= '0;
            cursor_reg     <= START_A;
            fill_reg       <= '0;
            tail_valid_reg <= '0;
            inflight_reg   <= 1'b0;
            occ_reg        <= 2'd0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            flag_reg       <= flag_next;
            pend_reg       <= pend_next;
            cursor_reg     <= cursor_next;
            fill_reg       <= fill_next;
            tail_valid_reg <= tail_valid_next;
            inflight_reg   <= inflight_next;
            occ_reg        <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seek_reg      <= seek_next;
        rd_addr_reg   <= rd_addr_next;
        cnt_reg       <= cnt_next;
        item_last_reg <= item_last_next;
        fl_last_reg   <= fl_last_next;
        src_reg       <= src_next;
        fwd_reg       <= fwd_next;
        q_data_reg[0] <= q_data_next[0];
        q_data_reg[1] <= q_data_next[1];
        q_last_reg[0] <= q_last_next[0];
        q_last_reg[1] <= q_last_next[1];
    end

endmodule

`default_nettype wire

### src/lzwd_checker.sv
// lzwd_checker: port-level assertions for the lzss window decoder, bound to the top level
// depends on lzwd_pkg and lzss_window_decoder
`default_nettype none

module lzwd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [7:0] in_byte,
    input wire logic       in_last,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       out_last
);

    // one full match plus what may still wait in the output queue
    localparam logic [4:0] OUT_LIMIT = lzwd_pkg::MAX_MATCH + 5'(lzwd_pkg::QUEUE_DEPTH);

    logic       in_acc;
    logic       out_acc;
    logic       seen_reg, seen_next;
    logic [4:0] run_reg, run_next;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_comb
    begin
        seen_next = seen_reg || in_acc;
        run_next  = run_reg;
        if (in_acc)
        begin
            run_next = {4'd0, out_acc};
        end
        else if (out_acc && run_reg != 5'h1f)
        begin
            run_next = run_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            run_reg  <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
            run_reg  <= run_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("output transaction changed while stalled");

    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_reg)
        else $error("output transaction before any input transaction");

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= OUT_LIMIT)
        else $error("too many output transactions for one input transaction");

    a_idle_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind lzss_window_decoder lzwd_checker u_lzwd_checker (.*);

`default_nettype wire

### test/tb.sv
// tb: self-checking testbench for lzss_window_decoder
// depends on lzwd_pkg and the decoder rtl; decodes every accepted byte in step with the dut
`timescale 1ns / 100ps

module tb;

    localparam int          WIN       = 4096;
    localparam logic [11:0] START_CUR = 12'(WIN - lzwd_pkg::LEN_TAIL);
    localparam int          N_ROWS    = 19;
    localparam int          N_ITEMS   = 130;

    typedef struct packed {
        logic [7:0] b;
        logic       l;
    } dec_byte_t;

    // one directed row: input byte, last flag, and typed-in results where obvious
    typedef struct packed {
        logic [7:0] b;
        logic       l;
        logic       typed;
        logic [4:0] n;
        logic [7:0] v;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;

    logic       idle_on = 1'b1;
    logic       row_typed = 1'b0;
    logic [4:0] row_n = 5'd0;
    logic [7:0] row_v = 8'h00;
    int         err_cnt = 0;
    int         sent = 0;

    // decoder state as the testbench sees it
    logic [7:0] hist [0:WIN-1];
    logic [11:0] cur;
    logic [8:0] flags;
    lzwd_pkg::phase_t ph;
    logic [7:0] low_b;

    dec_byte_t  pending_out [$];
    dec_byte_t  step_bytes [$];
    logic [7:0] stream_q [$];

    dir_row_t dir_rows [0:N_ROWS-1] = '{
        '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},  // control: eight matches
        '{8'hF0, 1'b0, 1'b1, 5'd0,  8'h00},
        '{8'hF0, 1'b0, 1'b1, 5'd3,  8'h00},  // top of window, still zero
        '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
        '{8'h0F, 1'b0, 1'b1, 5'd18, 8'h20},  // longest match from the fill area
        '{8'hFE, 1'b0, 1'b1, 5'd0,  8'h00},
        '{8'hF2, 1'b0, 1'b0, 5'd0,  8'h00},  // position wraps past the window end
        '{8'h12, 1'b0, 1'b1, 5'd0,  8'h00},
        '{8'h34, 1'b0, 1'b0, 5'd0,  8'h00},
        '{8'h55, 1'b1, 1'b1, 5'd0,  8'h00},  // stream ends inside a match
        '{8'hFF, 1'b1, 1'b1, 5'd0,  8'h00},  // stream ends on a control byte
        '{8'h03, 1'b0, 1'b1, 5'd0,  8'h00},
        '{8'hA5, 1'b0, 1'b1, 5'd1,  8'hA5},
        '{8'h5A, 1'b0, 1'b1, 5'd1,  8'h5A},
        '{8'hEE, 1'b0, 1'b1, 5'd0,  8'h00},
        '{8'hFF, 1'b1, 1'b0, 5'd0,  8'h00},  // overlapping copy closes the stream
        '{8'h03, 1'b0, 1'b1, 5'd0,  8'h00},
        '{8'h00, 1'b0, 1'b1, 5'd1,  8'h00},
        '{8'hFF, 1'b1, 1'b1, 5'd1,  8'hFF}
    };

    lzss_window_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void restart_stream();
        for (int i = 0; i < int'(START_CUR); i++)
            hist[i] = lzwd_pkg::FILL_BYTE;
        cur   = START_CUR;
        flags = 9'd0;
        ph    = lzwd_pkg::PH_CTRL;
        low_b = 8'h00;
    endfunction

    function automatic void store_byte(input logic [7:0] v);
        hist[cur] = v;
        cur       = cur + 12'd1;
    endfunction

    function automatic void next_flag();
        flags = flags >> 1;
        ph    = (flags <= 9'd1) ? lzwd_pkg::PH_CTRL : lzwd_pkg::PH_DATA;
    endfunction

    // decodes one compressed byte into step_bytes
    function automatic void decode_byte(input logic [7:0] b, input logic l);
        logic [11:0] pos;
        int          len;
        logic [7:0]  v;
        step_bytes.delete();
        case (ph)
            lzwd_pkg::PH_DATA:
            begin
                if (flags[0])
                begin
                    step_bytes.push_back('{b, 1'b0});
                    store_byte(b);
                    next_flag();
                end
                else
                begin
                    low_b = b;
                    ph    = lzwd_pkg::PH_HIGH;
                end
            end
            lzwd_pkg::PH_HIGH:
            begin
                pos = {b[7:4], low_b};
                len = int'(b[3:0]) + int'(lzwd_pkg::MIN_MATCH);
                for (int i = 0; i < len; i++)
                begin
                    v = hist[pos + 12'(i)];
                    step_bytes.push_back('{v, 1'b0});
                    store_byte(v);
                end
                next_flag();
            end
            default:
            begin
                flags = {1'b1, b};
                ph    = lzwd_pkg::PH_DATA;
            end
        endcase
        if (l)
        begin
            if (step_bytes.size() > 0)
                step_bytes[step_bytes.size() - 1].l = 1'b1;
            restart_stream();
        end
    endfunction

    // output side first, then the input transaction of the same edge
    always @(posedge clk)
    begin
        dec_byte_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_out.size() == 0)
                begin
                    if (err_cnt < 10)
                        $display("unexpected output: byte %h last %b", out_byte, out_last);
                    err_cnt++;
                end
                else
                begin
                    e = pending_out.pop_front();
                    if (e.b !== out_byte || e.l !== out_last)
                    begin
                        if (err_cnt < 10)
                            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                                     e.b, e.l, out_byte, out_last);
                        err_cnt++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                decode_byte(in_byte, in_last);
                if (row_typed)
                begin
                    for (int k = 0; k < int'(row_n); k++)
                        pending_out.push_back('{row_v, in_last && k == int'(row_n) - 1});
                end
                else
                begin
                    foreach (step_bytes[k])
                        pending_out.push_back(step_bytes[k]);
                end
            end
        end
    end

    always @(negedge clk)
        out_stall = idle_on && $urandom_range(99) < 35;

    // presents one byte and holds it until the transaction completes
    task automatic send_item(input logic [7:0] b, input logic l, input logic typed,
                             input logic [4:0] n, input logic [7:0] v);
        while (idle_on && $urandom_range(99) < 35)
        begin
            in_valid = 1'b0;
            in_byte  = 8'($urandom);
            in_last  = 1'($urandom);
            @(negedge clk);
        end
        in_valid  = 1'b1;
        in_byte   = b;
        in_last   = l;
        row_typed = typed;
        row_n     = n;
        row_v     = v;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending_out.size() != 0)
            @(negedge clk);
    endtask

    // builds one stream: mostly well formed, sometimes cut short, sometimes noise
    function automatic void plan_stream();
        int          groups;
        int          cut;
        logic [7:0]  ctl;
        logic [11:0] pc;
        logic [11:0] pos;
        logic [7:0]  hi;
        stream_q.delete();
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(1, 10))
                stream_q.push_back(8'($urandom));
            return;
        end
        pc     = START_CUR;
        groups = $urandom_range(1, 3);
        for (int g = 0; g < groups; g++)
        begin
            ctl = 8'($urandom);
            stream_q.push_back(ctl);
            for (int f = 0; f < 8; f++)
            begin
                if (ctl[f])
                begin
                    stream_q.push_back(8'($urandom));
                    pc = pc + 12'd1;
                end
                else
                begin
                    // near the cursor gives overlapping copies of fresh bytes
                    if ($urandom_range(99) < 60)
                        pos = pc - 12'($urandom_range(1, 40));
                    else
                        pos = 12'($urandom);
                    hi = {pos[11:8], 4'($urandom_range(15))};
                    stream_q.push_back(pos[7:0]);
                    stream_q.push_back(hi);
                    pc = pc + 12'(hi[3:0]) + 12'(lzwd_pkg::MIN_MATCH);
                end
            end
        end
        if ($urandom_range(99) < 20)
        begin
            cut = $urandom_range(1, stream_q.size());
            while (stream_q.size() > cut)
                void'(stream_q.pop_back());
        end
    endfunction

    initial
    begin
        for (int i = 0; i < WIN; i++)
            hist[i] = 8'h00;
        restart_stream();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < N_ROWS; r++)
            send_item(dir_rows[r].b, dir_rows[r].l, dir_rows[r].typed,
                      dir_rows[r].n, dir_rows[r].v);
        drain();

        while (sent < N_ITEMS)
        begin
            idle_on = !(sent >= 40 && sent < 80);
            plan_stream();
            foreach (stream_q[k])
            begin
                if (sent < N_ITEMS)
                    send_item(stream_q[k], k == stream_q.size() - 1, 1'b0, 5'd0, 8'h00);
            end
            if ($urandom_range(3) == 0)
                drain();
        end

        drain();
        repeat (40) @(negedge clk);
        if (err_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
src/lzwd_pkg.sv
src/lzwd_ram.sv
src/lzss_window_decoder.sv
src/lzwd_checker.sv
test/tb.sv
